/* hw/rtl/srv_pkg.sv */
package srv_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int STORE_W    = 32;
	localparam int NUM_LINES  = 7;
	localparam int NUM_AP     = 3;
	localparam int COMB_AW    = 13;
	localparam int MAX_AW     = COMB_AW + 1;
	localparam int CLR_LAST   = 2 ** MAX_AW - 1;
	localparam int MUL_AW     = 36;
	localparam int MUL_BW     = 18;
	localparam int PROD_W     = MUL_AW + MUL_BW;
	localparam int QOUT_W     = PROD_W - 15;

	localparam logic [17:0] AP_G         = 18'd22938;
	localparam logic [17:0] AP_ONE_MIN_G = 18'd9830;
	localparam logic [15:0] Q15_ONE      = 16'd32768;

	// register indexes of the configuration port
	localparam logic [2:0] CFG_SIZE   = 3'd0;
	localparam logic [2:0] CFG_DECAY  = 3'd1;
	localparam logic [2:0] CFG_GAIN_A = 3'd2;
	localparam logic [2:0] CFG_GAIN_B = 3'd3;
	localparam logic [2:0] CFG_GAIN_C = 3'd4;
	localparam logic [2:0] CFG_GAIN_D = 3'd5;
	localparam logic [2:0] CFG_MIX    = 3'd6;

	typedef enum logic [2:0] {
		PH_NONE,
		PH_M1,
		PH_M2,
		PH_M3,
		PH_X1,
		PH_X2,
		PH_X3
	} srv_phase_t;

	// command from controller to datapath
	typedef struct packed {
		logic              clr;
		logic [MAX_AW-1:0] clr_addr;
		logic              load;
		logic              rd;
		logic [2:0]        rd_line;
		srv_phase_t        phase;
		logic [2:0]        line;
	} srv_cmd_t;

	typedef struct packed {
		logic out_stall;
	} srv_sts_t;

	// circular length of each delay line
	function automatic int line_len(input int k);
		case (k)
			0: return 347;
			1: return 113;
			2: return 37;
			default: return 2 ** COMB_AW;
		endcase
	endfunction

	// memory address width, channel bit included
	function automatic int line_aw(input int k);
		case (k)
			0: return 10;
			1: return 8;
			2: return 7;
			default: return MAX_AW;
		endcase
	endfunction

	function automatic logic [11:0] comb_len(input logic [1:0] c);
		case (c)
			2'd0: return 12'd1687;
			2'd1: return 12'd1601;
			2'd2: return 12'd2053;
			default: return 12'd2251;
		endcase
	endfunction

	function automatic logic [15:0] comb_fb(input logic [1:0] c);
		case (c)
			2'd0: return 16'd25330;
			2'd1: return 16'd26280;
			2'd2: return 16'd24674;
			default: return 16'd25330;
		endcase
	endfunction

	// Q15 product, round half up
	function automatic logic signed [QOUT_W-1:0] q15_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(16384);
		return t[PROD_W-1:15];
	endfunction

	function automatic logic signed [STORE_W-1:0] sat32(input logic signed [QOUT_W:0] v);
		logic signed [QOUT_W:0] hi;
		logic signed [QOUT_W:0] lo;
		hi = (QOUT_W+1)'(2 ** 31 - 1);
		lo = -hi - 1;
		if (v > hi) return hi[STORE_W-1:0];
		if (v < lo) return lo[STORE_W-1:0];
		return v[STORE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [QOUT_W:0] v);
		logic signed [QOUT_W:0] hi;
		logic signed [QOUT_W:0] lo;
		hi = (QOUT_W+1)'(2 ** (SAMPLE_W - 1) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[SAMPLE_W-1:0];
		if (v < lo) return lo[SAMPLE_W-1:0];
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

/* hw/rtl/srv_ctrl.sv */
module srv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  srv_pkg::srv_sts_t sts,
	output srv_pkg::srv_cmd_t cmd
);
	import srv_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_RD    = 9'b000000100,
		S_M1    = 9'b000001000,
		S_M2    = 9'b000010000,
		S_M3    = 9'b000100000,
		S_X1    = 9'b001000000,
		S_X2    = 9'b010000000,
		S_X3    = 9'b100000000
	} state_t;

	localparam logic [2:0] LAST_LINE = 3'(NUM_LINES - 1);

	state_t            state_q, state_d;
	logic [2:0]        line_q, line_d;
	logic [MAX_AW-1:0] clr_q;

	assign in_ready = (state_q == S_IDLE);

	// next state and command decode
	always_comb begin
		state_d     = state_q;
		line_d      = line_q;
		cmd         = '0;
		cmd.phase   = PH_NONE;
		cmd.line    = line_q;
		cmd.clr_addr = clr_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (clr_q == MAX_AW'(CLR_LAST)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					line_d   = '0;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.rd      = 1'b1;
				cmd.rd_line = line_q;
				state_d     = S_M1;
			end
			S_M1: begin
				cmd.phase = PH_M1;
				state_d   = S_M2;
			end
			S_M2: begin
				cmd.phase = PH_M2;
				state_d   = S_M3;
			end
			S_M3: begin
				cmd.phase = PH_M3;
				if (line_q == LAST_LINE) begin
					state_d = S_X1;
				end else begin
					// fetch the next line while this one finishes
					cmd.rd      = 1'b1;
					cmd.rd_line = line_q + 3'd1;
					line_d      = line_q + 3'd1;
					state_d     = S_M1;
				end
			end
			S_X1: begin
				cmd.phase = PH_X1;
				state_d   = S_X2;
			end
			S_X2: begin
				cmd.phase = PH_X2;
				state_d   = S_X3;
			end
			S_X3: begin
				cmd.phase = PH_X3;
				if (!sts.out_stall) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			line_q  <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			line_q  <= line_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_fetch_before_m1: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_M1 |-> $past(cmd.rd) && $past(cmd.rd_line) == line_q)
		else $error("line data used without a fetch");
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && $past(state_q) == S_CLEAR |-> $past(clr_q) == MAX_AW'(CLR_LAST))
		else $error("clearing pass left early");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_X3 && !sts.out_stall |=> state_q == S_IDLE)
		else $error("result stage did not release");
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_X1 |-> line_q == LAST_LINE)
		else $error("mix started before last comb");
`endif

endmodule

/* hw/rtl/srv_dpath.sv */
module srv_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srv_pkg::srv_cmd_t                   cmd,
	output srv_pkg::srv_sts_t                   sts,
	input  logic                                in_channel_id,
	input  logic signed [srv_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_idx,
	input  logic [15:0]                         cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_channel,
	output logic signed [srv_pkg::SAMPLE_W-1:0] out_sample
);
	import srv_pkg::*;

	// configuration registers
	logic signed [11:0] size_off_q;
	logic signed [15:0] decay_q;
	logic [15:0]        gain_q [4];
	logic [15:0]        mix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_off_q <= '0;
			decay_q    <= '0;
			gain_q     <= '{default: Q15_ONE};
			mix_q      <= Q15_ONE;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SIZE:   size_off_q <= cfg_wdata[11:0];
				CFG_DECAY:  decay_q    <= cfg_wdata;
				CFG_GAIN_A: gain_q[0]  <= cfg_wdata;
				CFG_GAIN_B: gain_q[1]  <= cfg_wdata;
				CFG_GAIN_C: gain_q[2]  <= cfg_wdata;
				CFG_GAIN_D: gain_q[3]  <= cfg_wdata;
				CFG_MIX:    mix_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// working registers
	logic                       ch_q;
	logic signed [SAMPLE_W-1:0] dry_q;
	logic signed [STORE_W-1:0]  x_q;
	logic signed [STORE_W-1:0]  d_q;
	logic signed [MUL_AW-1:0]   wet_q;
	logic signed [QOUT_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic [COMB_AW-1:0]         wp_q [NUM_LINES][2];
	logic [STORE_W-1:0]         rdata_q [NUM_LINES];

	logic                       is_ap;
	logic [1:0]                 cidx;
	logic signed [16:0]         fb;
	logic [15:0]                mix_c;
	logic [16:0]                dry_gain;
	logic signed [STORE_W-1:0]  d_sel;
	logic signed [STORE_W-1:0]  xin;
	logic signed [QOUT_W-1:0]   q;
	logic signed [STORE_W-1:0]  wval;
	logic signed [MUL_AW-1:0]   mul_a;
	logic signed [MUL_BW-1:0]   mul_b;
	logic                       mul_en;
	logic [COMB_AW-1:0]         rd_idx [NUM_LINES];
	logic [NUM_LINES-1:0]       we, re;

	assign is_ap    = (cmd.line < 3'(NUM_AP));
	assign cidx     = 2'(cmd.line - 3'(NUM_AP));
	assign fb       = $signed({1'b0, comb_fb(cidx)}) + {decay_q[15], decay_q};
	assign mix_c    = (mix_q > Q15_ONE) ? Q15_ONE : mix_q;
	assign dry_gain = 17'(Q15_ONE) - {1'b0, mix_c};
	assign d_sel    = rdata_q[cmd.line];
	assign xin      = is_ap ? x_q : (x_q >>> 2);
	assign q        = q15_round(prod_s1);
	assign wval     = sat32({{(QOUT_W + 1 - STORE_W){xin[STORE_W-1]}}, xin} + {q[QOUT_W-1], q});

	// read addresses: allpass reads at the write pointer, combs behind it
	always_comb begin
		logic signed [13:0] dl;
		dl = '0;
		for (int k = 0; k < NUM_LINES; k++) begin
			if (k < NUM_AP) begin
				rd_idx[k] = wp_q[k][ch_q];
			end else begin
				dl = $signed({2'b00, comb_len(2'(k - NUM_AP))}) +
					{{2{size_off_q[11]}}, size_off_q};
				if (dl < 14'sd1) dl = 14'sd1;
				if (dl > 14'sd8191) dl = 14'sd8191;
				rd_idx[k] = wp_q[k][ch_q] - dl[COMB_AW-1:0];
			end
		end
	end

	// shared multiplier operand selection
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (cmd.phase)
			PH_M1: begin
				mul_a = MUL_AW'(d_sel);
				mul_b = is_ap ? AP_G : MUL_BW'(fb);
			end
			PH_M2: begin
				mul_a = MUL_AW'(d_q);
				mul_b = is_ap ? AP_ONE_MIN_G : {2'b00, gain_q[cidx]};
			end
			PH_X1: begin
				mul_a = MUL_AW'(dry_q);
				mul_b = {1'b0, dry_gain};
			end
			PH_X2: begin
				mul_a = wet_q;
				mul_b = {2'b00, mix_c};
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) prod_s1 <= mul_a * mul_b;
	end

	// sample path registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= in_channel_id;
			dry_q <= in_sample;
			x_q   <= STORE_W'(in_sample);
			wet_q <= '0;
		end
		if (cmd.phase == PH_M1) d_q <= d_sel;
		if (cmd.phase == PH_M3) begin
			if (is_ap)
				x_q <= sat32({q[QOUT_W-1], q} -
					{{(QOUT_W + 1 - STORE_W){x_q[STORE_W-1]}}, x_q});
			else
				wet_q <= wet_q + q[MUL_AW-1:0];
		end
		if (cmd.phase == PH_X2) acc_q <= q;
	end

	// write pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '{default: '{default: '0}};
		end else if (cmd.phase == PH_M3) begin
			for (int k = 0; k < NUM_LINES; k++) begin
				if (cmd.line == 3'(k)) begin
					if (wp_q[k][ch_q] == COMB_AW'(line_len(k) - 1))
						wp_q[k][ch_q] <= '0;
					else
						wp_q[k][ch_q] <= wp_q[k][ch_q] + 1'b1;
				end
			end
		end
	end

	// delay memories, one per line, channel in the top address bit
	for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
		localparam int AW = line_aw(k);
		logic [STORE_W-1:0] mem [2 ** AW];
		logic [AW-1:0]      waddr, raddr;
		logic [STORE_W-1:0] wdata;

		assign we[k]  = cmd.clr || (cmd.phase == PH_M2 && cmd.line == 3'(k));
		assign re[k]  = cmd.rd && cmd.rd_line == 3'(k);
		assign waddr  = cmd.clr ? cmd.clr_addr[AW-1:0] : {ch_q, wp_q[k][ch_q][AW-2:0]};
		assign raddr  = {ch_q, rd_idx[k][AW-2:0]};
		assign wdata  = cmd.clr ? '0 : wval;

		always_ff @(posedge clk) begin
			if (we[k]) mem[waddr] <= wdata;
			if (re[k]) rdata_q[k] <= mem[raddr];
		end
	end

	// output register
	assign sts.out_stall = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.phase == PH_X3 && !sts.out_stall) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.phase == PH_X3 && !sts.out_stall) begin
			out_channel <= ch_q;
			out_sample  <= sat24({acc_q[QOUT_W-1], acc_q} + {q[QOUT_W-1], q});
		end
	end

endmodule

/* hw/rtl/schroeder_reverb.sv */
// Each input sample is loaded, the delay lines are processed in turn and the result is
// registered to the master side; no new sample is taken before that. One shared multiplier
// does 16 products per sample over seven delay lines (three allpass, four comb) and the
// final wet/dry blend. Reset: arst_n clears control, configuration, write pointers, out_valid;
// a clearing pass then zeroes every delay memory, taking no sample (configuration still is).
module schroeder_reverb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] sample_in
	input  logic        s_axis_tuser,  // [0] channel_id
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [23:0] sample_out
	output logic        m_axis_tuser,  // [0] channel_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data
);
	import srv_pkg::*;

	srv_cmd_t cmd;
	srv_sts_t sts;
	logic     in_ready;

	assign s_axis_tready = in_ready;
	assign cfg_ready     = 1'b1;

	srv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srv_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_channel_id (s_axis_tuser),
		.in_sample     (s_axis_tdata),
		.cfg_we        (cfg_valid),
		.cfg_idx       (cfg_addr),
		.cfg_wdata     (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_channel   (m_axis_tuser),
		.out_sample    (m_axis_tdata)
	);

endmodule
